/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked at every rising edge of clk outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/ubd_pkg.sv */
// ----------------------------------------------------------------------------
// ubd_pkg
// types and constants of the uart baud divisor calculator
// ----------------------------------------------------------------------------
package ubd_pkg;

	localparam int CLK_W      = 28;
	localparam int BAUD_W     = 24;
	localparam int NUM_W      = 32;
	localparam int MANT_W     = 26;
	localparam int REM_W      = 7;
	localparam int WORD_W     = 16;
	localparam int DIV_STEPS  = NUM_W;
	localparam int PIPE_DEPTH = DIV_STEPS + 4;

	localparam logic [CLK_W-1:0] CLK_RESET = 28'd16000000;

	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT for any 32-bit x
	localparam logic [31:0] RECIP_100   = 32'h51EB851F;
	localparam int          RECIP_SHIFT = 37;

	// x / 100 == (x * FRAC_RECIP) >> FRAC_SHIFT for x below 1650
	localparam logic [12:0] FRAC_RECIP = 13'd5243;
	localparam int          FRAC_SHIFT = 19;

	localparam logic [6:0]  HUNDRED    = 7'd100;
	localparam logic [10:0] ROUND_HALF = 11'd50;
	localparam logic [11:0] MANT_MAX   = 12'hFFF;
	localparam logic [3:0]  FMAX_16    = 4'hF;
	localparam logic [3:0]  FMAX_8     = 4'h7;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_BAUD = 2'd1;
	localparam logic [1:0] ST_MANT_OVF  = 2'd2;

	typedef struct packed {
		logic [BAUD_W-1:0] baud_rate;
		logic              oversample_by_8;
	} ubd_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] divisor_word;
		logic [1:0]        status;
	} ubd_res_t;

	typedef struct packed {
		logic by8;
		logic zero;
	} ubd_side_t;

	typedef struct packed {
		logic [BAUD_W-1:0] rem;
		logic [NUM_W-1:0]  nq;
		logic [BAUD_W-1:0] den;
		ubd_side_t         side;
	} ubd_div_pay_t;

endpackage

/* rtl/ubd_div.sv */
// ----------------------------------------------------------------------------
// ubd_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module ubd_div import ubd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [BAUD_W-1:0] in_den,
	input  ubd_side_t         in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output ubd_side_t         out_side
);

	logic         vld_s [DIV_STEPS];
	ubd_div_pay_t pay_s [DIV_STEPS];

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		ubd_div_pay_t      src;
		logic              src_vld;
		logic [BAUD_W:0]   trial;
		logic [BAUD_W+1:0] diff;
		logic              ge;

		if (i == 0) begin : g_first
			assign src_vld = in_valid;
			assign src     = '{rem: '0, nq: in_num, den: in_den, side: in_side};
		end else begin : g_next
			assign src_vld = vld_s[i-1];
			assign src     = pay_s[i-1];
		end

		// shift in the next dividend bit, subtract when it fits
		assign trial = {src.rem, src.nq[NUM_W-1]};
		assign diff  = {1'b0, trial} - {2'b00, src.den};
		assign ge    = !diff[BAUD_W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			pay_s[i].rem  <= ge ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
			pay_s[i].nq   <= {src.nq[NUM_W-2:0], ge};
			pay_s[i].den  <= src.den;
			pay_s[i].side <= src.side;
		end
	end

	assign out_valid = vld_s[DIV_STEPS-1];
	assign out_quo   = pay_s[DIV_STEPS-1].nq;
	assign out_side  = pay_s[DIV_STEPS-1].side;

endmodule

/* rtl/uart_baud_divisor_calc_core.sv */
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_core
// uart divisor word (mantissa and rounded fraction) from a requested baud rate
// ----------------------------------------------------------------------------
// A request is taken in every cycle (busy never rises) and its result appears
// on result with done high for one cycle, in order. The pipeline runs through
// the 32-stage divider (one quotient bit per stage) plus an input stage, a
// reciprocal multiply for the split into mantissa and remainder, and the
// rounding stage that drives the output register. The clock register takes a
// write whenever cfg_valid is high; change it only while no request is in
// flight.
`include "assert_macros.svh"

module uart_baud_divisor_calc_core import ubd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ubd_req_t         request,
	output logic             done,
	output ubd_res_t         result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CLK_W-1:0] cfg_data
);

	logic [CLK_W-1:0] clk_hz_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			clk_hz_q <= cfg_data;
		end
	end

	// stage 1: numerator clk * 100, pre-divided by the oversampling factor
	logic              accept;
	logic [34:0]       clk100;
	logic              vld_s1;
	logic [NUM_W-1:0]  num_s1;
	logic [BAUD_W-1:0] den_s1;
	ubd_side_t         side_s1;

	assign accept = start && !busy;
	assign clk100 = {7'd0, clk_hz_q} * 35'(HUNDRED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		num_s1       <= request.oversample_by_8 ? clk100[34:3] : {1'b0, clk100[34:4]};
		den_s1       <= request.baud_rate;
		side_s1.by8  <= request.oversample_by_8;
		side_s1.zero <= (request.baud_rate == '0);
	end

	logic             div_vld;
	logic [NUM_W-1:0] d100;
	ubd_side_t        div_side;

	ubd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_num    (num_s1),
		.in_den    (den_s1),
		.in_side   (side_s1),
		.out_valid (div_vld),
		.out_quo   (d100),
		.out_side  (div_side)
	);

	// stage 2: reciprocal product for d100 / 100
	logic             vld_s2;
	logic [62:0]      prod_s2;
	logic [NUM_W-1:0] d100_s2;
	ubd_side_t        side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 63'(d100) * 63'(RECIP_100);
		d100_s2 <= d100;
		side_s2 <= div_side;
	end

	// stage 3: mantissa and remainder in hundredths
	logic [MANT_W-1:0] mant_c;
	logic [NUM_W-1:0]  rem_full;
	logic              vld_s3;
	logic [MANT_W-1:0] mant_s3;
	logic [REM_W-1:0]  rem_s3;
	ubd_side_t         side_s3;

	assign mant_c   = prod_s2[RECIP_SHIFT+MANT_W-1:RECIP_SHIFT];
	assign rem_full = d100_s2 - (NUM_W'(mant_c) * NUM_W'(HUNDRED));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mant_s3 <= mant_c;
		rem_s3  <= rem_full[REM_W-1:0];
		side_s3 <= side_s2;
	end

	// stage 4: rounded fraction, carry, saturation and packing
	logic [10:0]     frac_x;
	logic [23:0]     frac_p;
	logic [4:0]      frac;
	logic [3:0]      fmax;
	logic            carry;
	logic [MANT_W:0] mant_adj;
	ubd_res_t        res_c;
	logic            done_q;
	ubd_res_t        result_q;

	assign frac_x   = (side_s3.by8 ? {1'b0, rem_s3, 3'd0} : {rem_s3, 4'd0}) + ROUND_HALF;
	assign frac_p   = 24'(frac_x) * 24'(FRAC_RECIP);
	assign frac     = frac_p[FRAC_SHIFT+4:FRAC_SHIFT];
	assign fmax     = side_s3.by8 ? FMAX_8 : FMAX_16;
	assign carry    = (frac > {1'b0, fmax});
	assign mant_adj = {1'b0, mant_s3} + (MANT_W+1)'(carry);

	always_comb begin
		res_c.divisor_word = '0;
		res_c.status       = ST_OK;
		if (side_s3.zero) begin
			res_c.status = ST_ZERO_BAUD;
		end else if (mant_adj > (MANT_W+1)'(MANT_MAX)) begin
			res_c.divisor_word = {MANT_MAX, fmax};
			res_c.status       = ST_MANT_OVF;
		end else begin
			res_c.divisor_word = {mant_adj[11:0], (carry ? 4'd0 : frac[3:0]) & fmax};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

	`ASSERT_IMPLY(a_latency, accept, ##PIPE_DEPTH done, "result strobe missing after request")
	`ASSERT_CLK(a_by8_bit3, (vld_s3 && side_s3.by8) |=> !result.divisor_word[3], "bit 3 set by 8")
	`ASSERT_CLK(a_zero_baud, (vld_s3 && side_s3.zero) |=> (result.status == ST_ZERO_BAUD && result.divisor_word == '0), "zero baud result wrong")

endmodule

/* dv/uart_baud_divisor_calc_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_core_tb
// self-checking bench for the uart baud divisor calculator
// ----------------------------------------------------------------------------
// Requests go in on the start/busy handshake with random gaps, and a local
// divisor calculation predicts each result word. A monitor checks every done
// pulse against the oldest prediction. The clock register is rewritten
// between phases, and only once the pipeline has drained. The settings
// include zero and the full 28-bit value.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_core_tb;
	import ubd_pkg::*;

	localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;
	localparam int STALL_LIMIT  = 2000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	ubd_req_t         request = '0;
	logic             done;
	ubd_res_t         result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CLK_W-1:0] cfg_data = '0;

	ubd_res_t         pending_words[$];
	logic [CLK_W-1:0] clk_hz_model = CLK_RESET;
	int               mismatches = 0;
	int               stall_cycles = 0;
	bit               gaps_on = 1'b1;

	uart_baud_divisor_calc_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// divisor in hundredths, split into mantissa and rounded fraction
	function automatic ubd_res_t calc_divisor(input logic [CLK_W-1:0] hz, input ubd_req_t req);
		logic [63:0] scale;
		logic [63:0] top;
		logic [63:0] d100;
		logic [63:0] mant;
		logic [63:0] frac;
		ubd_res_t    res;
		scale = req.oversample_by_8 ? 64'd8 : 64'd16;
		top   = req.oversample_by_8 ? 64'(FMAX_8) : 64'(FMAX_16);
		res   = '0;
		if (req.baud_rate == '0) begin
			res.status = ST_ZERO_BAUD;
		end else begin
			d100 = (64'(hz) * 64'(HUNDRED)) / (scale * 64'(req.baud_rate));
			mant = d100 / 64'(HUNDRED);
			frac = ((d100 % 64'(HUNDRED)) * scale + 64'(ROUND_HALF)) / 64'(HUNDRED);
			// rounding up past the last step carries into the mantissa
			if (frac > top) begin
				mant = mant + 64'd1;
				frac = '0;
			end
			if (mant > 64'(MANT_MAX)) begin
				res.divisor_word = {MANT_MAX, top[3:0]};
				res.status       = ST_MANT_OVF;
			end else begin
				res.divisor_word = {mant[11:0], frac[3:0]};
				res.status       = ST_OK;
			end
		end
		return res;
	endfunction

	// prediction on accept, check on done, register model on write
	always @(posedge clk) begin
		ubd_res_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual divisor %h status %0d",
						$time, result.divisor_word, result.status);
					mismatches++;
				end else begin
					want = pending_words.pop_front();
					if (result.divisor_word !== want.divisor_word) begin
						$display("%0t: divisor_word mismatch: expected %h, actual %h",
							$time, want.divisor_word, result.divisor_word);
						mismatches++;
					end
					if (result.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, result.status);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				pending_words.push_back(calc_divisor(clk_hz_model, request));
			if (cfg_valid && cfg_ready)
				clk_hz_model = cfg_data;
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_request(input logic [BAUD_W-1:0] baud, input logic by8);
		int gap;
		gap = (gaps_on && $urandom_range(0, 99) < 10) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= '{baud_rate: baud, oversample_by_8: by8};
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic set_clock(input logic [CLK_W-1:0] hz);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data  <= hz;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [BAUD_W-1:0] pick_baud();
		logic [BAUD_W-1:0] common_rates[12] = '{300, 1200, 2400, 4800, 9600, 19200,
			38400, 57600, 115200, 230400, 460800, 921600};
		case ($urandom_range(0, 9))
			0, 1:    return common_rates[$urandom_range(0, 11)];
			2:       return BAUD_W'($urandom_range(1, 400));
			3:       return BAUD_W'($urandom);
			4:       return ($urandom_range(0, 3) == 0) ? '0 : BAUD_W'($urandom_range(1, 4000));
			default: return BAUD_W'($urandom_range(1, 12500000));
		endcase
	endfunction

	task automatic send_random(input int count);
		repeat (count) send_request(pick_baud(), 1'($urandom_range(0, 1)));
	endtask

	// field extremes and every flagged case at the reset clock
	task automatic test_directed();
		send_request('0, 1'b0);
		send_request('0, 1'b1);
		send_request(24'd1, 1'b0);
		send_request(24'd1, 1'b1);
		send_request(24'd12500000, 1'b0);
		send_request(24'd12500000, 1'b1);
		send_request('1, 1'b0);
		send_request('1, 1'b1);
		send_request(24'd9600, 1'b0);
		send_request(24'd115200, 1'b0);
		send_request(24'd115200, 1'b1);
		send_request(24'd244, 1'b0);
		send_request(24'd245, 1'b1);
		send_request(24'd1000000, 1'b0);
		send_request(24'h555555, 1'b1);
		send_request(24'hAAAAAA, 1'b0);
	endtask

	// zero, full-scale and 1 Hz clocks; zero clock gives a zero divisor with ok status for a nonzero baud
	task automatic test_clock_extremes();
		set_clock('0);
		send_request(24'd9600, 1'b0);
		send_request(24'd1, 1'b1);
		send_request('0, 1'b0);
		set_clock('1);
		send_request(24'd1, 1'b0);
		send_request(24'd12500000, 1'b1);
		send_request('1, 1'b0);
		set_clock(28'd1);
		send_request(24'd1, 1'b0);
		send_request(24'd1, 1'b1);
		send_request('1, 1'b1);
	endtask

	task automatic test_clock_sweep();
		logic [CLK_W-1:0] clocks[6] = '{28'd1, 28'd200000000, 28'hFFFFFFF, 28'd42000000,
			28'd84000000, 28'd8000000};
		foreach (clocks[i]) begin
			set_clock(clocks[i]);
			send_random(40);
		end
		set_clock(CLK_W'($urandom_range(1, 200000000)));
		send_random(30);
	endtask

	// back-to-back words, then a full drain before the rest
	task automatic test_random_stream();
		set_clock(CLK_RESET);
		gaps_on = 1'b0;
		send_random(100);
		gaps_on = 1'b1;
		wait_drain();
		send_random(60);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_clock_extremes();
		test_clock_sweep();
		test_random_stream();
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
